/* design/tbn_pkg.sv */
// Shared types, codes and helper functions for the tournament barrier node.
// Used by tbn_ctrl, tbn_datapath and tournament_barrier_node; no dependencies.
`default_nettype none

package tbn_pkg;

    // sizes
    localparam int MAX_NODES   = 64;
    localparam int MAX_THREADS = 64;
    localparam int MAX_RESULTS = 8;
    localparam int NODE_W      = 6;
    localparam int CNT_W       = 7;
    localparam int ROUND_W     = 3;
    localparam int ROUNDS      = 6;
    localparam int RES_W       = 4;
    localparam int KIND_W      = 2;
    localparam int CFG_IDX_W   = 2;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SEND    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DONE    = 2'd2;

    // per-round roles
    localparam logic [1:0] ROLE_BYE      = 2'd0;
    localparam logic [1:0] ROLE_WINNER   = 2'd1;
    localparam logic [1:0] ROLE_LOSER    = 2'd2;
    localparam logic [1:0] ROLE_CHAMPION = 2'd3;

    // tournament phase
    localparam logic [1:0] PH_IDLE      = 2'd0;
    localparam logic [1:0] PH_WAIT_ARR  = 2'd1;
    localparam logic [1:0] PH_WAIT_WAKE = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_NODES   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NODE_ID     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_THREADS = 2'd2;

    // datapath operations
    typedef logic [3:0] t_op;
    localparam t_op OP_NONE   = 4'd0;
    localparam t_op OP_LOAD   = 4'd1;
    localparam t_op OP_ARRIVE = 4'd2;
    localparam t_op OP_MSG    = 4'd3;
    localparam t_op OP_START  = 4'd4;
    localparam t_op OP_CLIMB  = 4'd5;
    localparam t_op OP_DESC   = 4'd6;
    localparam t_op OP_FIN    = 4'd7;
    localparam t_op OP_FLUSH  = 4'd8;

    // outcome of one climb step at the current round
    localparam logic [1:0] CL_STAY = 2'd0;
    localparam logic [1:0] CL_FIN  = 2'd1;
    localparam logic [1:0] CL_WAIT = 2'd2;
    localparam logic [1:0] CL_DESC = 2'd3;

    // outcome of a received message
    localparam logic [1:0] MSG_NONE  = 2'd0;
    localparam logic [1:0] MSG_CLIMB = 2'd1;
    localparam logic [1:0] MSG_DESC  = 2'd2;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic       single;
        logic       thr_last;
        logic       busy;
        logic       func;
        logic [1:0] climb;
        logic       desc_zero;
        logic [1:0] msg;
        logic       defer_go;
        logic       hold;
        logic       pend_valid;
    } t_stat;

    // clamp a count register to 1..max
    function automatic logic [CNT_W-1:0] clamp_cnt(input logic [CNT_W-1:0] v,
                                                   input logic [CNT_W-1:0] max_v);
        logic [CNT_W-1:0] c;
        c = v;
        if (v == '0) c = CNT_W'(1);
        else if (v > max_v) c = max_v;
        return c;
    endfunction

    // rounds in the tournament: ceil(log2(p))
    function automatic logic [ROUND_W-1:0] num_rounds(input logic [CNT_W-1:0] p);
        logic [ROUND_W-1:0] r;
        r = '0;
        for (int j = 0; j < ROUNDS; j++) begin
            if ((CNT_W'(1) << j) < p) r = ROUND_W'(j + 1);
        end
        return r;
    endfunction

    // role of node id in round k
    function automatic logic [1:0] role_of(input logic [ROUND_W-1:0] k,
                                           input logic [NODE_W-1:0]  id,
                                           input logic [CNT_W-1:0]   p,
                                           input logic [ROUND_W-1:0] r);
        logic [CNT_W-1:0] half;
        logic [CNT_W-1:0] full;
        logic [CNT_W-1:0] low;
        logic [CNT_W-1:0] id_x;
        logic [1:0]       role;
        role = ROLE_BYE;
        id_x = {1'b0, id};
        half = CNT_W'(1) << (k - ROUND_W'(1));
        full = {half[CNT_W-2:0], 1'b0};
        low  = id_x & (full - CNT_W'(1));
        if (k != '0 && k <= r) begin
            if (low == '0) begin
                if (id == '0 && full >= p) role = ROLE_CHAMPION;
                else if (id_x + half < p) role = ROLE_WINNER;
            end else if (low == half) begin
                role = ROLE_LOSER;
            end
        end
        return role;
    endfunction

endpackage

`default_nettype wire

/* design/tournament_barrier_node.sv */
// Barrier controller for one node of a combined sense-reversing tournament
// barrier. Items are taken one at a time: the input is ready again only once
// the sequencer is back in idle, after the item's steps (count down or latch a
// message, climb the rounds, walk back down, the done step) and any deferred
// start that is due. The sequencer in tbn_ctrl handles one round per cycle and
// stalls while both the held result and the output register are full and the
// output is not ready. Results of an item leave one per cycle while the output
// is ready, through a one-deep hold and an output register, with tlast on the
// final one; at most eight results per item are delivered.
// Depends on tbn_pkg, tbn_ctrl and tbn_datapath.
`default_nettype none

module tournament_barrier_node
    import tbn_pkg::*;
(
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    // configuration write port
    input  wire                 i_cfg_we,
    input  wire [CFG_IDX_W-1:0] i_cfg_index,
    input  wire [CNT_W-1:0]     i_cfg_data,
    // input items
    input  wire                 s_axis_tvalid,
    output logic                s_axis_tready,
    input  wire [7:0]           s_axis_tdata,   // [5:0] from_node, [7:6] zero
    input  wire                 s_axis_tuser,   // [0] func
    // result items
    output logic                m_axis_tvalid,
    input  wire                 m_axis_tready,
    output logic [7:0]          m_axis_tdata,   // [5:0] dest_node, [6] sense_value
    output logic [KIND_W-1:0]   m_axis_tuser,   // [1:0] kind
    output logic                m_axis_tlast
);

    t_cmd              cmd;
    t_stat             stat;
    logic [NODE_W-1:0] out_dest;
    logic              out_sense;

    tbn_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    tbn_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_item_func (s_axis_tuser),
        .i_item_from (s_axis_tdata[NODE_W-1:0]),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_kind  (m_axis_tuser),
        .o_out_dest  (out_dest),
        .o_out_sense (out_sense),
        .o_out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, out_sense, out_dest};

`ifndef SYNTHESIS
    // a new item is only taken once the previous one left no held result
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !stat.pend_valid)
        else $error("item accepted while a result is still held");

    // one item at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second item accepted while busy");

    // no step advances while the output side is blocked
    a_no_step_on_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.op != OP_NONE) |-> !stat.hold)
        else $error("step issued while results are stalled");
`endif

endmodule

`default_nettype wire

/* design/tbn_ctrl.sv */
// Sequencer for the tournament barrier node: walks one item through its steps.
// Depends on tbn_pkg; drives tbn_datapath through t_cmd and reads t_stat.
`default_nettype none

module tbn_ctrl
    import tbn_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ITEM  = 3'd1;
    localparam logic [2:0] ST_CLIMB = 3'd2;
    localparam logic [2:0] ST_DESC  = 3'd3;
    localparam logic [2:0] ST_FIN   = 3'd4;
    localparam logic [2:0] ST_DEFER = 3'd5;
    localparam logic [2:0] ST_FLUSH = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_in_ready = (r_state == ST_IDLE);

    // next state and command; nothing moves while the result path is full
    always_comb begin
        n_state  = r_state;
        o_cmd.op = OP_NONE;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = ST_ITEM;
                end
            end
            ST_ITEM: begin
                if (!i_stat.hold) begin
                    if (!i_stat.func) begin
                        o_cmd.op = OP_ARRIVE;
                        if (i_stat.thr_last && !i_stat.busy)
                            n_state = i_stat.single ? ST_FIN : ST_CLIMB;
                        else
                            n_state = ST_DEFER;
                    end else if (i_stat.single) begin
                        n_state = ST_DEFER;
                    end else begin
                        o_cmd.op = OP_MSG;
                        case (i_stat.msg)
                            MSG_CLIMB: n_state = ST_CLIMB;
                            MSG_DESC:  n_state = ST_DESC;
                            default:   n_state = ST_DEFER;
                        endcase
                    end
                end
            end
            ST_CLIMB: begin
                if (!i_stat.hold) begin
                    case (i_stat.climb)
                        CL_FIN: n_state = ST_FIN;
                        CL_WAIT: begin
                            o_cmd.op = OP_CLIMB;
                            n_state  = ST_DEFER;
                        end
                        CL_DESC: begin
                            o_cmd.op = OP_CLIMB;
                            n_state  = ST_DESC;
                        end
                        default: o_cmd.op = OP_CLIMB;
                    endcase
                end
            end
            ST_DESC: begin
                if (!i_stat.hold) begin
                    if (i_stat.desc_zero) n_state = ST_FIN;
                    else o_cmd.op = OP_DESC;
                end
            end
            ST_FIN: begin
                if (!i_stat.hold) begin
                    o_cmd.op = OP_FIN;
                    n_state  = ST_DEFER;
                end
            end
            ST_DEFER: begin
                if (!i_stat.hold) begin
                    if (i_stat.defer_go) begin
                        o_cmd.op = OP_START;
                        n_state  = i_stat.single ? ST_FIN : ST_CLIMB;
                    end else begin
                        n_state = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH: begin
                if (!i_stat.hold) begin
                    o_cmd.op = OP_FLUSH;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

/* design/tbn_datapath.sv */
// Datapath of the tournament barrier node: configuration, barrier state,
// round roles, one held result and the output register. Depends on tbn_pkg.
`default_nettype none

module tbn_datapath
    import tbn_pkg::*;
(
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  t_cmd                   i_cmd,
    output t_stat                  o_stat,
    input  wire                    i_cfg_we,
    input  wire [CFG_IDX_W-1:0]    i_cfg_index,
    input  wire [CNT_W-1:0]        i_cfg_data,
    input  wire                    i_item_func,
    input  wire [NODE_W-1:0]       i_item_from,
    output logic                   o_out_valid,
    input  wire                    i_out_ready,
    output logic [KIND_W-1:0]      o_out_kind,
    output logic [NODE_W-1:0]      o_out_dest,
    output logic                   o_out_sense,
    output logic                   o_out_last
);

    // configuration
    logic [CNT_W-1:0]   r_num_nodes, n_num_nodes;
    logic [NODE_W-1:0]  r_node_id, n_node_id;
    logic [CNT_W-1:0]   r_num_threads, n_num_threads;

    // barrier state
    logic [CNT_W-1:0]   r_thr_left, n_thr_left;
    logic               r_gsense, n_gsense;
    logic               r_nsense, n_nsense;
    logic [ROUND_W-1:0] r_cur, n_cur;
    logic [1:0]         r_phase, n_phase;
    logic [ROUNDS-1:0]  r_arr_seen, n_arr_seen;
    logic               r_wake_seen, n_wake_seen;
    logic               r_defer, n_defer;
    logic [ROUND_W-1:0] r_k, n_k;

    // item and result counting
    logic               r_func, n_func;
    logic [NODE_W-1:0]  r_from, n_from;
    logic [RES_W-1:0]   r_cnt, n_cnt;

    // held result, waiting to learn whether it is the last one
    logic               r_pend_v, n_pend_v;
    logic [KIND_W-1:0]  r_pend_kind, n_pend_kind;
    logic [NODE_W-1:0]  r_pend_dest, n_pend_dest;
    logic               r_pend_sense, n_pend_sense;

    // output register
    logic               r_out_v, n_out_v;
    logic [KIND_W-1:0]  r_out_kind, n_out_kind;
    logic [NODE_W-1:0]  r_out_dest, n_out_dest;
    logic               r_out_sense, n_out_sense;
    logic               r_out_last, n_out_last;

    // derived values
    logic [CNT_W-1:0]   eff_p;
    logic [CNT_W-1:0]   eff_t;
    logic [ROUND_W-1:0] rounds;
    logic               single;
    logic [1:0]         role_k;
    logic [CNT_W-1:0]   half_k;
    logic [ROUND_W-1:0] k_m1;
    logic               seen_k;
    logic [NODE_W-1:0]  dest_up;
    logic [NODE_W-1:0]  dest_dn;
    logic [1:0]         climb_code;

    // message search
    logic               hit_arr;
    logic               hit_wake;
    logic [ROUND_W-1:0] hit_k;
    logic [1:0]         msg_code;

    // result request
    logic               emit_req;
    logic [KIND_W-1:0]  emit_kind;
    logic [NODE_W-1:0]  emit_dest;
    logic               emit_sense;
    logic               hold;

    assign eff_p   = clamp_cnt(r_num_nodes, CNT_W'(MAX_NODES));
    assign eff_t   = clamp_cnt(r_num_threads, CNT_W'(MAX_THREADS));
    assign rounds  = num_rounds(eff_p);
    assign single  = (eff_p == CNT_W'(1)) || ({1'b0, r_node_id} >= eff_p);
    assign role_k  = role_of(r_k, r_node_id, eff_p, rounds);
    assign half_k  = CNT_W'(1) << (r_k - ROUND_W'(1));
    assign k_m1    = r_k - ROUND_W'(1);
    assign seen_k  = (k_m1 < ROUND_W'(ROUNDS)) ? r_arr_seen[k_m1] : 1'b0;
    assign dest_up = NODE_W'({1'b0, r_node_id} + half_k);
    assign dest_dn = NODE_W'({1'b0, r_node_id} - half_k);

    // what one climb step at round k does
    always_comb begin
        climb_code = CL_STAY;
        if (r_k == '0 || r_k > rounds) begin
            climb_code = CL_FIN;
        end else begin
            case (role_k)
                ROLE_WINNER:   climb_code = seen_k ? CL_STAY : CL_WAIT;
                ROLE_LOSER:    climb_code = r_wake_seen ? CL_DESC : CL_WAIT;
                ROLE_CHAMPION: climb_code = seen_k ? CL_DESC : CL_WAIT;
                default:       climb_code = CL_STAY;
            endcase
        end
    end

    // classify a message: lowest round whose opponent is the sender
    always_comb begin
        logic [1:0]       role_j;
        logic [CNT_W-1:0] half_j;
        hit_arr  = 1'b0;
        hit_wake = 1'b0;
        hit_k    = '0;
        for (int j = ROUNDS; j >= 1; j--) begin
            role_j = role_of(ROUND_W'(j), r_node_id, eff_p, rounds);
            half_j = CNT_W'(1) << (j - 1);
            if ((role_j == ROLE_WINNER || role_j == ROLE_CHAMPION) &&
                ({1'b0, r_from} == {1'b0, r_node_id} + half_j)) begin
                hit_arr  = 1'b1;
                hit_wake = 1'b0;
                hit_k    = ROUND_W'(j);
            end else if (role_j == ROLE_LOSER &&
                         ({1'b0, r_from} + half_j == {1'b0, r_node_id})) begin
                hit_arr  = 1'b0;
                hit_wake = 1'b1;
                hit_k    = ROUND_W'(j);
            end
        end
        msg_code = MSG_NONE;
        if (hit_arr && r_phase == PH_WAIT_ARR && r_cur == hit_k) msg_code = MSG_CLIMB;
        else if (hit_wake && r_phase == PH_WAIT_WAKE) msg_code = MSG_DESC;
    end

    // output side cannot take the held result this cycle
    assign hold = r_pend_v && r_out_v && !i_out_ready;

    // state updates per command
    always_comb begin
        n_num_nodes   = r_num_nodes;
        n_node_id     = r_node_id;
        n_num_threads = r_num_threads;
        n_thr_left    = r_thr_left;
        n_gsense      = r_gsense;
        n_nsense      = r_nsense;
        n_cur         = r_cur;
        n_phase       = r_phase;
        n_arr_seen    = r_arr_seen;
        n_wake_seen   = r_wake_seen;
        n_defer       = r_defer;
        n_k           = r_k;
        n_func        = r_func;
        n_from        = r_from;
        n_cnt         = r_cnt;
        n_pend_v      = r_pend_v;
        n_pend_kind   = r_pend_kind;
        n_pend_dest   = r_pend_dest;
        n_pend_sense  = r_pend_sense;
        n_out_v       = r_out_v && !i_out_ready;
        n_out_kind    = r_out_kind;
        n_out_dest    = r_out_dest;
        n_out_sense   = r_out_sense;
        n_out_last    = r_out_last;
        emit_req      = 1'b0;
        emit_kind     = KIND_RELEASE;
        emit_dest     = '0;
        emit_sense    = 1'b0;

        case (i_cmd.op)
            OP_LOAD: begin
                n_func = i_item_func;
                n_from = i_item_from;
                n_cnt  = '0;
            end
            OP_ARRIVE: begin
                if (r_thr_left <= CNT_W'(1)) begin
                    n_thr_left = eff_t;
                    n_gsense   = ~r_gsense;
                    emit_req   = 1'b1;
                    emit_kind  = KIND_RELEASE;
                    emit_sense = ~r_gsense;
                    if (r_phase != PH_IDLE) n_defer = 1'b1;
                    else n_k = ROUND_W'(1);
                end else begin
                    n_thr_left = r_thr_left - CNT_W'(1);
                end
            end
            OP_MSG: begin
                if (hit_arr) begin
                    n_arr_seen[hit_k - ROUND_W'(1)] = 1'b1;
                    if (msg_code == MSG_CLIMB) n_k = hit_k;
                end else if (hit_wake) begin
                    if (r_phase == PH_WAIT_WAKE) begin
                        n_wake_seen = 1'b0;
                        n_k         = r_cur - ROUND_W'(1);
                    end else begin
                        n_wake_seen = 1'b1;
                    end
                end
            end
            OP_START: begin
                n_defer = 1'b0;
                n_k     = ROUND_W'(1);
            end
            OP_CLIMB: begin
                case (role_k)
                    ROLE_WINNER: begin
                        if (seen_k) begin
                            n_arr_seen[k_m1] = 1'b0;
                            n_k = r_k + ROUND_W'(1);
                        end else begin
                            n_phase = PH_WAIT_ARR;
                            n_cur   = r_k;
                        end
                    end
                    ROLE_LOSER: begin
                        emit_req   = 1'b1;
                        emit_kind  = KIND_SEND;
                        emit_dest  = dest_dn;
                        emit_sense = r_nsense;
                        if (r_wake_seen) begin
                            n_wake_seen = 1'b0;
                            n_k = k_m1;
                        end else begin
                            n_phase = PH_WAIT_WAKE;
                            n_cur   = r_k;
                        end
                    end
                    ROLE_CHAMPION: begin
                        if (seen_k) begin
                            n_arr_seen[k_m1] = 1'b0;
                            emit_req   = 1'b1;
                            emit_kind  = KIND_SEND;
                            emit_dest  = dest_up;
                            emit_sense = r_nsense;
                            n_k = k_m1;
                        end else begin
                            n_phase = PH_WAIT_ARR;
                            n_cur   = r_k;
                        end
                    end
                    default: n_k = r_k + ROUND_W'(1);
                endcase
            end
            OP_DESC: begin
                if (role_k == ROLE_WINNER) begin
                    emit_req   = 1'b1;
                    emit_kind  = KIND_SEND;
                    emit_dest  = dest_up;
                    emit_sense = r_nsense;
                end
                n_k = k_m1;
            end
            OP_FIN: begin
                n_nsense   = ~r_nsense;
                emit_req   = 1'b1;
                emit_kind  = KIND_DONE;
                emit_sense = ~r_nsense;
                n_phase    = PH_IDLE;
                n_cur      = '0;
            end
            default: ;
        endcase

        // new result: the held one goes out, the new one is held
        if (emit_req && r_cnt < RES_W'(MAX_RESULTS)) begin
            if (r_pend_v) begin
                n_out_v     = 1'b1;
                n_out_kind  = r_pend_kind;
                n_out_dest  = r_pend_dest;
                n_out_sense = r_pend_sense;
                n_out_last  = 1'b0;
            end
            n_pend_v     = 1'b1;
            n_pend_kind  = emit_kind;
            n_pend_dest  = emit_dest;
            n_pend_sense = emit_sense;
            n_cnt        = r_cnt + RES_W'(1);
        end

        // end of the item: held result is the last one
        if (i_cmd.op == OP_FLUSH && r_pend_v) begin
            n_out_v     = 1'b1;
            n_out_kind  = r_pend_kind;
            n_out_dest  = r_pend_dest;
            n_out_sense = r_pend_sense;
            n_out_last  = 1'b1;
            n_pend_v    = 1'b0;
        end

        // configuration writes
        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_NUM_NODES: n_num_nodes = i_cfg_data;
                CFG_NODE_ID:   n_node_id   = i_cfg_data[NODE_W-1:0];
                CFG_NUM_THREADS: begin
                    n_num_threads = i_cfg_data;
                    n_thr_left    = clamp_cnt(i_cfg_data, CNT_W'(MAX_THREADS));
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_nodes   <= CNT_W'(1);
            r_node_id     <= '0;
            r_num_threads <= CNT_W'(1);
            r_thr_left    <= CNT_W'(1);
            r_gsense      <= 1'b1;
            r_nsense      <= 1'b1;
            r_cur         <= '0;
            r_phase       <= PH_IDLE;
            r_arr_seen    <= '0;
            r_wake_seen   <= 1'b0;
            r_defer       <= 1'b0;
            r_k           <= '0;
            r_pend_v      <= 1'b0;
            r_out_v       <= 1'b0;
        end else begin
            r_num_nodes   <= n_num_nodes;
            r_node_id     <= n_node_id;
            r_num_threads <= n_num_threads;
            r_thr_left    <= n_thr_left;
            r_gsense      <= n_gsense;
            r_nsense      <= n_nsense;
            r_cur         <= n_cur;
            r_phase       <= n_phase;
            r_arr_seen    <= n_arr_seen;
            r_wake_seen   <= n_wake_seen;
            r_defer       <= n_defer;
            r_k           <= n_k;
            r_pend_v      <= n_pend_v;
            r_out_v       <= n_out_v;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_func       <= n_func;
        r_from       <= n_from;
        r_cnt        <= n_cnt;
        r_pend_kind  <= n_pend_kind;
        r_pend_dest  <= n_pend_dest;
        r_pend_sense <= n_pend_sense;
        r_out_kind   <= n_out_kind;
        r_out_dest   <= n_out_dest;
        r_out_sense  <= n_out_sense;
        r_out_last   <= n_out_last;
    end

    // status to the sequencer
    always_comb begin
        o_stat.single     = single;
        o_stat.thr_last   = (r_thr_left <= CNT_W'(1));
        o_stat.busy       = (r_phase != PH_IDLE);
        o_stat.func       = r_func;
        o_stat.climb      = climb_code;
        o_stat.desc_zero  = (r_k == '0);
        o_stat.msg        = msg_code;
        o_stat.defer_go   = (r_phase == PH_IDLE) && r_defer;
        o_stat.hold       = hold;
        o_stat.pend_valid = r_pend_v;
    end

    assign o_out_valid = r_out_v;
    assign o_out_kind  = r_out_kind;
    assign o_out_dest  = r_out_dest;
    assign o_out_sense = r_out_sense;
    assign o_out_last  = r_out_last;

endmodule

`default_nettype wire

/* tb/tbn_checker.sv */
// Scoreboard for tournament_barrier_node: mirrors the node's barrier state,
// predicts the results of every accepted item and compares them in order.
// Depends on tbn_pkg for widths, result kinds, roles, phases and register indexes.
`default_nettype none

module tbn_checker
    import tbn_pkg::*;
(
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_we,
    input  wire [CFG_IDX_W-1:0] i_cfg_index,
    input  wire [CNT_W-1:0]     i_cfg_data,
    input  wire                 i_s_tvalid,
    input  wire                 i_s_tready,
    input  wire [7:0]           i_s_tdata,   // [5:0] from_node, [7:6] zero
    input  wire                 i_s_tuser,   // [0] func
    input  wire                 i_m_tvalid,
    input  wire                 i_m_tready,
    input  wire [7:0]           i_m_tdata,   // [5:0] dest_node, [6] sense_value
    input  wire [KIND_W-1:0]    i_m_tuser,   // [1:0] kind
    input  wire                 i_m_tlast,
    output int                  o_fail_count,
    output int                  o_pending
);

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [NODE_W-1:0] dest;
        logic              sense;
        logic              last;
    } t_barrier_result;

    // shadow registers
    logic [CNT_W-1:0]   cfg_nodes;
    logic [NODE_W-1:0]  cfg_id;
    logic [CNT_W-1:0]   cfg_threads;

    // shadow barrier state
    logic [CNT_W-1:0]   thr_left;
    logic               g_sense;
    logic               n_sense;
    logic [ROUND_W-1:0] cur_round;
    logic [1:0]         tour_phase;
    logic [7:0]         arr_seen;
    logic               wake_seen;
    logic               start_late;

    t_barrier_result    step_res[$];
    t_barrier_result    result_q[$];
    int                 fails = 0;

    function automatic int clamp_to(input int v, input int max_v);
        if (v < 1) return 1;
        if (v > max_v) return max_v;
        return v;
    endfunction

    function automatic int nodes_eff();
        return clamp_to(int'(cfg_nodes), MAX_NODES);
    endfunction

    function automatic int rounds_cnt();
        int p;
        int r;
        p = nodes_eff();
        r = 0;
        while (r < 7 && (1 << r) < p) r++;
        return r;
    endfunction

    function automatic bit lone_node();
        return nodes_eff() == 1 || int'(cfg_id) >= nodes_eff();
    endfunction

    function automatic logic [1:0] round_role(input int k);
        int p;
        int i;
        int half;
        int full;
        p = nodes_eff();
        i = int'(cfg_id);
        if (k < 1 || k > rounds_cnt()) return ROLE_BYE;
        half = 1 << (k - 1);
        full = 1 << k;
        if ((i & (full - 1)) == 0) begin
            if (i == 0 && full >= p) return ROLE_CHAMPION;
            if (i + half < p) return ROLE_WINNER;
            return ROLE_BYE;
        end
        if ((i & (full - 1)) == half) return ROLE_LOSER;
        return ROLE_BYE;
    endfunction

    // results past the per-item limit are dropped
    function automatic void push_result(input logic [KIND_W-1:0] kind, input int dest,
                                        input logic sense);
        t_barrier_result r;
        if (step_res.size() >= MAX_RESULTS) return;
        r.kind  = kind;
        r.dest  = NODE_W'(dest);
        r.sense = sense;
        r.last  = 1'b0;
        step_res.push_back(r);
    endfunction

    function automatic void complete_barrier();
        n_sense = ~n_sense;
        push_result(KIND_DONE, 0, n_sense);
        tour_phase = PH_IDLE;
        cur_round  = '0;
    endfunction

    // wake every loser beaten on the way up, then report done
    function automatic void walk_down(input int from);
        for (int k = from; k >= 1; k--) begin
            if (round_role(k) == ROLE_WINNER)
                push_result(KIND_SEND, int'(cfg_id) + (1 << (k - 1)), n_sense);
        end
        complete_barrier();
    endfunction

    function automatic void climb_from(input int k0);
        int k;
        int r;
        k = k0;
        r = rounds_cnt();
        while (1) begin
            if (k < 1 || k > r || k >= 8) begin
                complete_barrier();
                return;
            end
            case (round_role(k))
                ROLE_WINNER: begin
                    if (!arr_seen[k]) begin
                        tour_phase = PH_WAIT_ARR;
                        cur_round  = ROUND_W'(k);
                        return;
                    end
                    arr_seen[k] = 1'b0;
                    k++;
                end
                ROLE_LOSER: begin
                    push_result(KIND_SEND, int'(cfg_id) - (1 << (k - 1)), n_sense);
                    if (wake_seen) begin
                        wake_seen = 1'b0;
                        walk_down(k - 1);
                    end else begin
                        tour_phase = PH_WAIT_WAKE;
                        cur_round  = ROUND_W'(k);
                    end
                    return;
                end
                ROLE_CHAMPION: begin
                    if (!arr_seen[k]) begin
                        tour_phase = PH_WAIT_ARR;
                        cur_round  = ROUND_W'(k);
                        return;
                    end
                    arr_seen[k] = 1'b0;
                    push_result(KIND_SEND, int'(cfg_id) + (1 << (k - 1)), n_sense);
                    walk_down(k - 1);
                    return;
                end
                default: k++;
            endcase
        end
    endfunction

    function automatic void start_round_trip();
        if (lone_node()) complete_barrier();
        else climb_from(1);
    endfunction

    // a peer message is either a round arrival, our wakeup, or ignored
    function automatic void handle_message(input int from);
        int r;
        int half;
        logic [1:0] role;
        r = rounds_cnt();
        for (int k = 1; k <= r && k < 8; k++) begin
            role = round_role(k);
            half = 1 << (k - 1);
            if ((role == ROLE_WINNER || role == ROLE_CHAMPION) &&
                from == int'(cfg_id) + half) begin
                arr_seen[k] = 1'b1;
                if (tour_phase == PH_WAIT_ARR && int'(cur_round) == k) climb_from(k);
                return;
            end
            if (role == ROLE_LOSER && from + half == int'(cfg_id)) begin
                if (tour_phase == PH_WAIT_WAKE) begin
                    wake_seen = 1'b0;
                    walk_down(int'(cur_round) - 1);
                end else begin
                    wake_seen = 1'b1;
                end
                return;
            end
        end
    endfunction

    function automatic void predict_item(input logic func, input logic [NODE_W-1:0] from);
        step_res.delete();
        if (func == 1'b0) begin
            if (thr_left <= 1) begin
                thr_left = CNT_W'(clamp_to(int'(cfg_threads), MAX_THREADS));
                g_sense  = ~g_sense;
                push_result(KIND_RELEASE, 0, g_sense);
                if (tour_phase != PH_IDLE) start_late = 1'b1;
                else start_round_trip();
            end else begin
                thr_left = thr_left - 1'b1;
            end
        end else if (!lone_node()) begin
            handle_message(int'(from));
        end
        // a start that came in while busy runs as soon as the node is idle
        if (tour_phase == PH_IDLE && start_late) begin
            start_late = 1'b0;
            start_round_trip();
        end
        if (step_res.size() > 0) step_res[step_res.size() - 1].last = 1'b1;
        foreach (step_res[j]) result_q.push_back(step_res[j]);
    endfunction

    function automatic void check_result(input t_barrier_result got);
        t_barrier_result want;
        if (result_q.size() == 0) begin
            fails++;
            if (fails <= 10)
                $display("unexpected result: kind %0d dest %0d sense %0d last %0d",
                         got.kind, got.dest, got.sense, got.last);
            return;
        end
        want = result_q.pop_front();
        if (got.kind !== want.kind || got.dest !== want.dest ||
            got.sense !== want.sense || got.last !== want.last) begin
            fails++;
            if (fails <= 10) begin
                $display("result mismatch: expected kind %0d dest %0d sense %0d last %0d",
                         want.kind, want.dest, want.sense, want.last);
                $display("                 got      kind %0d dest %0d sense %0d last %0d",
                         got.kind, got.dest, got.sense, got.last);
            end
        end
    endfunction

    // track register writes, accepted items and accepted results
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_nodes   = CNT_W'(1);
            cfg_id      = '0;
            cfg_threads = CNT_W'(1);
            thr_left    = CNT_W'(1);
            g_sense     = 1'b1;
            n_sense     = 1'b1;
            cur_round   = '0;
            tour_phase  = PH_IDLE;
            arr_seen    = '0;
            wake_seen   = 1'b0;
            start_late  = 1'b0;
            result_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_NUM_NODES: cfg_nodes = i_cfg_data;
                    CFG_NODE_ID:   cfg_id = i_cfg_data[NODE_W-1:0];
                    CFG_NUM_THREADS: begin
                        cfg_threads = i_cfg_data;
                        thr_left    = CNT_W'(clamp_to(int'(i_cfg_data), MAX_THREADS));
                    end
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready)
                predict_item(i_s_tuser, i_s_tdata[NODE_W-1:0]);
            if (i_m_tvalid && i_m_tready)
                check_result({i_m_tuser, i_m_tdata[NODE_W-1:0], i_m_tdata[NODE_W], i_m_tlast});
        end
        o_pending    <= result_q.size();
        o_fail_count <= fails;
    end

endmodule

`default_nettype wire

/* tb/tb_tournament_barrier_node.sv */
// Top of the tournament_barrier_node testbench: clock, reset, register writes,
// item stimulus with peer message episodes, output back-pressure and verdict.
// Depends on tbn_pkg, tbn_checker and the tournament_barrier_node RTL.
`default_nettype none

module tb_tournament_barrier_node;
    import tbn_pkg::*;

    // index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_ITEMS   = 44;

    typedef struct packed {
        logic              func;
        logic [NODE_W-1:0] from;
    } t_node_item;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = '0;
    logic [CNT_W-1:0]     cfg_data = '0;
    logic                 in_valid = 1'b0;
    wire                  in_ready;
    logic [7:0]           in_data = '0;
    logic                 in_user = 1'b0;
    wire                  out_valid;
    logic                 out_ready = 1'b0;
    wire  [7:0]           out_data;
    wire  [KIND_W-1:0]    out_user;
    wire                  out_last;
    int                   fail_count;
    int                   pending;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_requests = 0;
    int holds_served = 0;
    int hold_left = 0;

    // settings the stimulus builds its episodes from
    int cur_nodes = 1;
    int cur_id = 0;
    int cur_threads = 1;

    tournament_barrier_node u_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_idx),
        .i_cfg_data    (cfg_data),
        .s_axis_tvalid (in_valid),
        .s_axis_tready (in_ready),
        .s_axis_tdata  (in_data),
        .s_axis_tuser  (in_user),
        .m_axis_tvalid (out_valid),
        .m_axis_tready (out_ready),
        .m_axis_tdata  (out_data),
        .m_axis_tuser  (out_user),
        .m_axis_tlast  (out_last)
    );

    tbn_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_s_tvalid   (in_valid),
        .i_s_tready   (in_ready),
        .i_s_tdata    (in_data),
        .i_s_tuser    (in_user),
        .i_m_tvalid   (out_valid),
        .i_m_tready   (out_ready),
        .i_m_tdata    (out_data),
        .i_m_tuser    (out_user),
        .i_m_tlast    (out_last),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        #3000000;
        $display("Simulation FAILED");
        $finish;
    end

    // result side: random stalls, plus long hold-offs on request
    always @(posedge clk) begin
        if (hold_left > 0) begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (holds_served != hold_requests) begin
            holds_served <= holds_served + 1;
            hold_left    <= HOLD_CYCLES;
            out_ready    <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic int clamp_count(input int v);
        if (v < 1) return 1;
        if (v > MAX_NODES) return MAX_NODES;
        return v;
    endfunction

    // offer one item, wait for acceptance, then maybe go idle a while
    task automatic offer_item(input logic func, input logic [NODE_W-1:0] from);
        in_valid <= 1'b1;
        in_user  <= func;
        in_data  <= {2'b00, from};
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge clk);
        end
    endtask

    // stop offering until every expected result is out and the node is quiet
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    task automatic configure(input int nodes, input int id7, input int thr);
        write_reg(CFG_NUM_NODES, CNT_W'(nodes));
        write_reg(CFG_NODE_ID, CNT_W'(id7));
        write_reg(CFG_NUM_THREADS, CNT_W'(thr));
        write_reg(CFG_SPARE, CNT_W'($urandom_range(127)));
        cfg_we      <= 1'b0;
        cur_nodes   = clamp_count(nodes);
        cur_id      = id7 & 63;
        cur_threads = clamp_count(thr);
    endtask

    // one barrier episode: local arrivals plus the peer messages this node
    // needs, shuffled, sometimes with an item lost or repeated
    task automatic run_episode(output int count);
        t_node_item ep[$];
        t_node_item it;
        int half;
        int low;
        int j;
        int pick;
        for (j = 0; j < cur_threads; j++) begin
            it.func = 1'b0;
            it.from = NODE_W'($urandom_range(63));
            ep.push_back(it);
        end
        if (cur_nodes > 1 && cur_id < cur_nodes) begin
            for (int k = 1; (1 << (k - 1)) < cur_nodes; k++) begin
                half    = 1 << (k - 1);
                low     = cur_id & ((1 << k) - 1);
                it.func = 1'b1;
                if (low == 0) begin
                    if (cur_id + half < cur_nodes) begin
                        it.from = NODE_W'(cur_id + half);
                        ep.push_back(it);
                    end
                end else if (low == half) begin
                    it.from = NODE_W'(cur_id - half);
                    ep.push_back(it);
                    break;
                end
            end
        end
        pick = $urandom_range(99);
        if (pick < 8 && ep.size() > 1) ep.delete($urandom_range(ep.size() - 1));
        else if (pick < 16) ep.push_back(ep[$urandom_range(ep.size() - 1)]);
        for (j = ep.size() - 1; j > 0; j--) begin
            pick     = $urandom_range(j);
            it       = ep[j];
            ep[j]    = ep[pick];
            ep[pick] = it;
        end
        foreach (ep[m]) offer_item(ep[m].func, ep[m].from);
        count = ep.size();
    endtask

    initial begin
        int items;
        int n;
        int p;
        int id;
        bit paused;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single node after reset: done at once, messages ignored
        offer_item(1'b0, NODE_W'($urandom_range(63)));
        offer_item(1'b1, 6'd63);
        drain();

        // champion of 64 with every arrival early: the longest result burst
        configure(64, 0, 1);
        for (int k = 0; k < ROUNDS; k++) offer_item(1'b1, NODE_W'(1 << k));
        offer_item(1'b0, 6'd0);
        // repeated early arrival, then a second start while still climbing
        offer_item(1'b1, 6'd1);
        offer_item(1'b1, 6'd1);
        offer_item(1'b0, 6'd0);
        offer_item(1'b0, 6'd0);
        for (int k = 1; k < ROUNDS; k++) offer_item(1'b1, NODE_W'(1 << k));
        for (int k = 0; k < ROUNDS; k++) offer_item(1'b1, NODE_W'(1 << k));
        drain();

        // highest id loses round one; its wakeup comes in early
        configure(64, 63, 1);
        offer_item(1'b1, 6'd62);
        offer_item(1'b0, 6'd0);
        drain();

        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0: configure(64, 0, 1);
                1: configure(127, $urandom_range(63), 64);
                2: configure(0, $urandom_range(127), 0);
                default: begin
                    p  = $urandom_range(2, MAX_NODES);
                    id = ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(p - 1);
                    configure(p, id | ($urandom_range(1) << 6), $urandom_range(1, 4));
                end
            endcase
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
                default: begin send_idle_pct = 25; recv_stall_pct = 25; end
            endcase
            // long hold-off on the result side while items keep coming
            if (ph == 4) hold_requests = hold_requests + 1;
            items  = 0;
            paused = 1'b0;
            while (items < PHASE_ITEMS) begin
                if (ph == 5 && !paused && items >= PHASE_ITEMS / 2) begin
                    drain();
                    paused = 1'b1;
                end
                if ($urandom_range(99) < 85) begin
                    run_episode(n);
                    items += n;
                end else begin
                    offer_item(1'($urandom_range(1)), NODE_W'($urandom_range(63)));
                    items++;
                end
            end
            drain();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
